// ===== sv/spwm_pkg.sv =====
// ----------------------------------------------------------------------------
// spwm_pkg: shared types and constants of the sine PWM H-bridge generator
// Register indexes, controller states and the control/status bundles that
// run between the controller and the datapath.
// ----------------------------------------------------------------------------
package spwm_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  localparam int CARRIER_W = 16;
  localparam int PHASE_W   = 32;
  localparam int AMP_W     = 13;
  localparam int SINE_W    = 16;
  localparam int MAG_W     = 15;
  localparam int SCALED_W  = AMP_W + MAG_W;
  localparam int ON_SHIFT  = 27;

  localparam logic [CFG_INDEX_W-1:0] CFG_CARRIER_TICKS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_STEP    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_AMPLITUDE     = 2'd2;

  localparam logic [CARRIER_W-1:0] CARRIER_TICKS_RST = 16'd20;
  localparam logic [PHASE_W-1:0]   PHASE_STEP_RST    = 32'd51746593;
  localparam logic [AMP_W-1:0]     AMPLITUDE_RST     = 13'd1861;
  localparam logic [AMP_W-1:0]     AMP_FULL_SCALE    = 13'd4096;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROM_READ,
    ST_AMP_MUL,
    ST_LEN_MUL,
    ST_COMMIT
  } spwm_state_t;

  typedef struct packed {
    logic take;
    logic commit;
  } spwm_cmd_t;

  typedef struct packed {
    logic carrier_due;
    logic out_free;
  } spwm_status_t;

endpackage

// ===== sv/spwm_in_if.sv =====
// ----------------------------------------------------------------------------
// spwm_in_if: tick input channel
// One transfer per time tick; run low brakes the bridge.
// ----------------------------------------------------------------------------
interface spwm_in_if;
  logic valid;
  logic ready;
  logic run;

  modport source (output valid, output run, input ready);
  modport sink (input valid, input run, output ready);
endinterface

// ===== sv/spwm_out_if.sv =====
// ----------------------------------------------------------------------------
// spwm_out_if: bridge drive output channel
// One transfer per tick: the two leg levels and the carrier start flag.
// ----------------------------------------------------------------------------
interface spwm_out_if;
  logic valid;
  logic ready;
  logic drive_forward;
  logic drive_reverse;
  logic carrier_start;

  modport source (output valid, output drive_forward, output drive_reverse,
                  output carrier_start, input ready);
  modport sink (input valid, input drive_forward, input drive_reverse,
                input carrier_start, output ready);
endinterface

// ===== sv/spwm_ctrl.sv =====
// ----------------------------------------------------------------------------
// spwm_ctrl: tick sequencer
// Takes ticks, and on a carrier's first tick steps the datapath through the
// sine lookup and the two scaling multiplies before the result is committed.
// ----------------------------------------------------------------------------
module spwm_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  spwm_pkg::spwm_status_t status,
  output spwm_pkg::spwm_cmd_t    cmd
);
  import spwm_pkg::*;

  spwm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd.take   = 1'b0;
    cmd.commit = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = status.out_free;
        if (in_valid && status.out_free) begin
          cmd.take = 1'b1;
          if (status.carrier_due) begin
            state_nxt = ST_ROM_READ;
          end
        end
      end
      ST_ROM_READ: state_nxt = ST_AMP_MUL;
      ST_AMP_MUL:  state_nxt = ST_LEN_MUL;
      ST_LEN_MUL:  state_nxt = ST_COMMIT;
      ST_COMMIT: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== sv/spwm_dp.sv =====
// ----------------------------------------------------------------------------
// spwm_dp: PWM datapath
// Configuration registers, carrier counter, phase accumulator, sine ROM,
// on-time scaling multiplies and the output register.
// ----------------------------------------------------------------------------
module spwm_dp #(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int TICK_COUNT_WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [spwm_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [spwm_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                                  in_run,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic                                  out_drive_forward,
  output logic                                  out_drive_reverse,
  output logic                                  out_carrier_start,
  input  spwm_pkg::spwm_cmd_t                   cmd,
  output spwm_pkg::spwm_status_t                status
);
  import spwm_pkg::*;

  localparam int TW     = TICK_COUNT_WIDTH;
  localparam int IW     = $clog2(SINE_TABLE_DEPTH);
  localparam int DW     = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int IPW    = PHASE_W + DW;
  localparam int LPW    = TW + SCALED_W;

  typedef logic signed [SINE_W-1:0] rom_t [SINE_TABLE_DEPTH];

  // Quarter-wave polynomial, Q16 in, Q15 out
  function automatic logic signed [SINE_W-1:0] sine_entry(int unsigned k);
    longint unsigned q, r, t, u, p, s, m;
    logic signed [SINE_W-1:0] e;
    q = (longint'(k) * 4) / SINE_TABLE_DEPTH;
    r = (longint'(k) * 4) % SINE_TABLE_DEPTH;
    t = (r * 65536) / SINE_TABLE_DEPTH;
    if (q[0]) begin
      t = 65536 - t;
    end
    u = (t * t) >> 16;
    p = 5223 - ((u * 307) >> 16);
    p = 42335 - ((u * p) >> 16);
    p = 102944 - ((u * p) >> 16);
    s = (t * p) >> 16;
    m = (s * 32767 + 32768) >> 16;
    if (m > 32767) begin
      m = 32767;
    end
    e = m[SINE_W-1:0];
    if (q >= 2) begin
      e = -e;
    end
    return e;
  endfunction

  function automatic rom_t build_rom();
    rom_t rom;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      rom[k] = sine_entry(k);
    end
    return rom;
  endfunction

  localparam rom_t SineRom = build_rom();

  logic [CARRIER_W-1:0] carrier_ticks_r;
  logic [PHASE_W-1:0]   phase_step_r;
  logic [AMP_W-1:0]     amplitude_r;

  logic [TW-1:0]        tick_r, tick_nxt;
  logic [PHASE_W-1:0]   sine_phase_r, sine_phase_nxt;
  logic [TW-1:0]        on_ticks_r, on_ticks_nxt;
  logic                 negative_r, negative_nxt;

  logic [IW-1:0]        idx_r;
  logic signed [SINE_W-1:0] rom_r;
  logic [SCALED_W-1:0]  scaled_r;
  logic                 neg_new_r;
  logic [TW-1:0]        on_new_r;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_fwd_r, out_fwd_nxt;
  logic                 out_rev_r, out_rev_nxt;
  logic                 out_start_r, out_start_nxt;

  logic [TW-1:0]        len;
  logic [IPW-1:0]       idx_prod;
  logic [MAG_W-1:0]     mag;
  logic [LPW-1:0]       len_prod;
  logic [TW:0]          tick_inc;
  logic [TW-1:0]        tick_adv;
  logic                 high;
  logic [AMP_W-1:0]     amp_wdata;

  assign len       = TW'(carrier_ticks_r);
  assign idx_prod  = IPW'(sine_phase_r) * IPW'(SINE_TABLE_DEPTH);
  assign mag       = rom_r[SINE_W-1] ? MAG_W'(-rom_r) : MAG_W'(rom_r);
  assign len_prod  = LPW'(len) * LPW'(scaled_r);
  assign tick_inc  = {1'b0, tick_r} + {{TW{1'b0}}, 1'b1};
  assign tick_adv  = (tick_inc >= {1'b0, len}) ? '0 : tick_inc[TW-1:0];
  assign amp_wdata = cfg_wdata[AMP_W-1:0];

  assign status.carrier_due = in_run && (tick_r == '0);
  assign status.out_free    = !out_valid_r || out_ready;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carrier_ticks_r <= CARRIER_TICKS_RST;
      phase_step_r    <= PHASE_STEP_RST;
      amplitude_r     <= AMPLITUDE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CARRIER_TICKS: carrier_ticks_r <= cfg_wdata[CARRIER_W-1:0];
        CFG_PHASE_STEP:    phase_step_r    <= cfg_wdata[PHASE_W-1:0];
        CFG_AMPLITUDE:     amplitude_r     <= (amp_wdata > AMP_FULL_SCALE) ?
                                              AMP_FULL_SCALE : amp_wdata;
        default: ;
      endcase
    end
  end

  // on-time pipeline: index multiply, ROM read, amplitude and length scaling
  always_ff @(posedge clk) begin
    idx_r     <= idx_prod[PHASE_W +: IW];
    rom_r     <= SineRom[idx_r];
    scaled_r  <= SCALED_W'(amplitude_r) * SCALED_W'(mag);
    neg_new_r <= rom_r[SINE_W-1];
    on_new_r  <= len_prod[ON_SHIFT +: TW];
  end

  always_comb begin
    tick_nxt       = tick_r;
    sine_phase_nxt = sine_phase_r;
    on_ticks_nxt   = on_ticks_r;
    negative_nxt   = negative_r;
    out_valid_nxt  = out_ready ? 1'b0 : out_valid_r;
    out_fwd_nxt    = out_fwd_r;
    out_rev_nxt    = out_rev_r;
    out_start_nxt  = out_start_r;
    high           = 1'b0;
    if (cmd.take && !in_run) begin
      // brake
      tick_nxt       = '0;
      sine_phase_nxt = '0;
      out_valid_nxt  = 1'b1;
      out_fwd_nxt    = 1'b1;
      out_rev_nxt    = 1'b1;
      out_start_nxt  = 1'b0;
    end else if (cmd.take && !status.carrier_due) begin
      high          = tick_r < on_ticks_r;
      tick_nxt      = tick_adv;
      out_valid_nxt = 1'b1;
      out_fwd_nxt   = high && !negative_r;
      out_rev_nxt   = high && negative_r;
      out_start_nxt = 1'b0;
    end else if (cmd.commit) begin
      high           = on_new_r != '0;
      on_ticks_nxt   = on_new_r;
      negative_nxt   = neg_new_r;
      sine_phase_nxt = sine_phase_r + phase_step_r;
      tick_nxt       = tick_adv;
      out_valid_nxt  = 1'b1;
      out_fwd_nxt    = high && !neg_new_r;
      out_rev_nxt    = high && neg_new_r;
      out_start_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r       <= '0;
      sine_phase_r <= '0;
      on_ticks_r   <= '0;
      negative_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      tick_r       <= tick_nxt;
      sine_phase_r <= sine_phase_nxt;
      on_ticks_r   <= on_ticks_nxt;
      negative_r   <= negative_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_fwd_r   <= out_fwd_nxt;
    out_rev_r   <= out_rev_nxt;
    out_start_r <= out_start_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_drive_forward = out_fwd_r;
  assign out_drive_reverse = out_rev_r;
  assign out_carrier_start = out_start_r;

endmodule

// ===== sv/sine_pwm_h_bridge_generator.sv =====
// ----------------------------------------------------------------------------
// sine_pwm_h_bridge_generator: sine-modulated PWM for an H-bridge
// Each tick transfer on in_tick gives one drive transfer on out_drive.
//
// in_tick carries run; run high advances the waveform one tick, run low
// brakes (both legs high) and clears the carrier position and the phase.
// out_drive carries the forward and reverse leg levels and a flag that
// marks the first tick of a carrier period.
// cfg_we/cfg_index/cfg_wdata write carrier_ticks (0), phase_step (1) and
// amplitude (2, clamped to 4096); write only while no tick is in flight.
// Brake and mid-carrier ticks reach the output register in the cycle
// after the transfer. A carrier's first tick passes through the steps
// phase-to-index multiply, sine ROM read, amplitude multiply, carrier
// length multiply and commit, and no new tick is taken until commit.
// A stalled out_drive holds its result; one new tick is taken in
// the cycle the waiting result is transferred.
// Reset restores the register defaults and clears phase, carrier position
// and on-time; the output comes up empty.
// ----------------------------------------------------------------------------
module sine_pwm_h_bridge_generator #(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int TICK_COUNT_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  spwm_in_if.sink                          in_tick,
  spwm_out_if.source                       out_drive,
  input  logic                             cfg_we,
  input  logic [spwm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [spwm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import spwm_pkg::*;

  spwm_cmd_t    cmd;
  spwm_status_t status;

  spwm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tick.valid),
    .in_ready (in_tick.ready),
    .status   (status),
    .cmd      (cmd)
  );

  spwm_dp #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_run            (in_tick.run),
    .out_ready         (out_drive.ready),
    .out_valid         (out_drive.valid),
    .out_drive_forward (out_drive.drive_forward),
    .out_drive_reverse (out_drive.drive_reverse),
    .out_carrier_start (out_drive.carrier_start),
    .cmd               (cmd),
    .status            (status)
  );

endmodule

// ===== bench/sine_pwm_h_bridge_generator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sine_pwm_h_bridge_generator_tb: self-checking bench for the sine PWM bridge
// Feeds run/brake ticks with random gaps and output stalls, and sweeps
// carrier length, phase step and amplitude, extremes included. Every drive
// transfer is checked against an in-bench predictor of the PWM waveform.
// ----------------------------------------------------------------------------
module sine_pwm_h_bridge_generator_tb;
  import spwm_pkg::*;

  localparam int SINE_DEPTH  = 1024;
  localparam int HOLD_AT     = 250;
  localparam int HOLD_CYCLES = 160;
  localparam int PHASES      = 6;
  localparam int PHASE_TICKS = 80;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

  typedef enum int { PACE_FULL, PACE_RANDOM, PACE_SPARSE } pace_t;

  typedef struct packed {
    logic fwd;
    logic rev;
    logic start;
  } bridge_drive_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  spwm_in_if  tick_if ();
  spwm_out_if drive_if ();

  sine_pwm_h_bridge_generator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tick   (tick_if),
    .out_drive (drive_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // register copies and waveform state of the predictor
  logic [CARRIER_W-1:0] carrier_len;
  logic [PHASE_W-1:0]   phase_inc;
  logic [AMP_W-1:0]     amp_depth;
  logic [CARRIER_W-1:0] tick_pos;
  logic [PHASE_W-1:0]   phase_acc;
  logic [CARRIER_W-1:0] on_cnt;
  logic                 rev_half;
  int                   sine_q15 [SINE_DEPTH];

  logic          tick_queue [$];
  bridge_drive_t drive_expected [$];

  pace_t in_pace;
  pace_t out_pace;
  int    tick_gap;
  int    drive_stall;
  int    hold_left;
  logic  hold_done;
  int    drives_seen;
  int    ticks_sent;
  int    brakes_sent;
  int    starts_seen;
  int    mismatches;
  int    settings_run;

  function automatic int sine_q15_at(input int k);
    longint unsigned q, r, t, u, p, s, m;
    q = (longint'(k) * 4) / SINE_DEPTH;
    r = (longint'(k) * 4) % SINE_DEPTH;
    t = (r * 65536) / SINE_DEPTH;
    if (q[0]) t = 65536 - t;
    u = (t * t) >> 16;
    p = 5223 - ((u * 307) >> 16);
    p = 42335 - ((u * p) >> 16);
    p = 102944 - ((u * p) >> 16);
    s = (t * p) >> 16;
    m = (s * 32767 + 32768) >> 16;
    if (m > 32767) m = 32767;
    return (q >= 2) ? -int'(m) : int'(m);
  endfunction

  function automatic bridge_drive_t predict_drive(input logic run);
    bridge_drive_t   d;
    int              sv;
    longint unsigned mag, prod;
    logic            on_high;
    d = '0;
    if (!run) begin
      tick_pos  = '0;
      phase_acc = '0;
      d.fwd     = 1'b1;
      d.rev     = 1'b1;
      return d;
    end
    if (tick_pos == '0) begin
      sv       = sine_q15[phase_acc[PHASE_W-1 -: 10]];
      rev_half = (sv < 0);
      mag      = rev_half ? -sv : sv;
      prod     = carrier_len * amp_depth * mag;
      on_cnt   = prod[ON_SHIFT +: CARRIER_W];
      phase_acc = phase_acc + phase_inc;
      d.start  = 1'b1;
    end
    on_high = (tick_pos < on_cnt);
    d.fwd   = on_high && !rev_half;
    d.rev   = on_high && rev_half;
    if ({1'b0, tick_pos} + 17'd1 >= {1'b0, carrier_len}) tick_pos = '0;
    else tick_pos = tick_pos + 1'b1;
    return d;
  endfunction

  function automatic int draw_wait(input pace_t pace);
    case (pace)
      PACE_RANDOM: return $urandom_range(0, 8);
      PACE_SPARSE: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
      default:     return 0;
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    case (idx)
      CFG_CARRIER_TICKS: carrier_len = value[CARRIER_W-1:0];
      CFG_PHASE_STEP:    phase_inc = value[PHASE_W-1:0];
      CFG_AMPLITUDE:     amp_depth = (value[AMP_W-1:0] > AMP_FULL_SCALE) ?
                                     AMP_FULL_SCALE : value[AMP_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic queue_ticks(input logic run, input int count);
    repeat (count) tick_queue.push_back(run);
  endtask

  task automatic wait_idle(input int max_cycles);
    int n;
    n = 0;
    while ((tick_queue.size() != 0 || drive_expected.size() != 0) && n < max_cycles) begin
      @(posedge clk);
      n++;
    end
  endtask

  task automatic flag_mismatch(input string what, input bridge_drive_t want,
                               input bridge_drive_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected fwd=%b rev=%b start=%b, got fwd=%b rev=%b start=%b",
               $time, what, want.fwd, want.rev, want.start, got.fwd, got.rev, got.start);
  endtask

  // tick driver
  always @(posedge clk) begin : tick_driver
    logic next_valid;
    logic next_run;
    next_valid = tick_if.valid;
    next_run   = tick_if.run;
    if (!rst_n) begin
      tick_gap   = 0;
      next_valid = 1'b0;
    end else begin
      if (tick_if.valid && tick_if.ready) begin
        drive_expected.push_back(predict_drive(tick_if.run));
        void'(tick_queue.pop_front());
        ticks_sent++;
        if (!tick_if.run) brakes_sent++;
        tick_gap   = draw_wait(in_pace);
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (tick_gap != 0) begin
          tick_gap--;
        end else if (tick_queue.size() != 0) begin
          next_valid = 1'b1;
          next_run   = tick_queue[0];
        end
      end
    end
    tick_if.valid <= next_valid;
    tick_if.run   <= next_run;
  end

  // long receiver hold-off, once, so that the block backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && drives_seen >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // drive monitor
  always @(posedge clk) begin : drive_monitor
    bridge_drive_t got;
    bridge_drive_t want;
    if (!rst_n) begin
      drive_stall = 0;
      drive_if.ready <= 1'b0;
    end else begin
      if (drive_if.valid && drive_if.ready) begin
        got = '{drive_if.drive_forward, drive_if.drive_reverse, drive_if.carrier_start};
        drives_seen <= drives_seen + 1;
        if (got.start === 1'b1) starts_seen++;
        if (drive_expected.size() == 0) begin
          flag_mismatch("drive transfer with nothing outstanding", '0, got);
        end else begin
          want = drive_expected.pop_front();
          if (got.fwd !== want.fwd || got.rev !== want.rev || got.start !== want.start)
            flag_mismatch("drive mismatch", want, got);
        end
        drive_stall = draw_wait(out_pace);
      end
      if (drive_stall != 0) begin
        drive_stall--;
        drive_if.ready <= 1'b0;
      end else begin
        drive_if.ready <= (hold_left == 0);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("sine_pwm_h_bridge_generator regression: fail");
    $finish;
  end

  initial begin
    int sel, n, burst;
    logic [31:0] v;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    tick_if.valid  = 1'b0;
    tick_if.run    = 1'b0;
    drive_if.ready = 1'b0;
    in_pace        = PACE_RANDOM;
    out_pace       = PACE_SPARSE;
    drives_seen    = 0;
    ticks_sent     = 0;
    brakes_sent    = 0;
    starts_seen    = 0;
    mismatches     = 0;
    settings_run   = 0;
    for (int k = 0; k < SINE_DEPTH; k++) sine_q15[k] = sine_q15_at(k);
    carrier_len = CARRIER_TICKS_RST;
    phase_inc   = PHASE_STEP_RST;
    amp_depth   = AMPLITUDE_RST;
    tick_pos    = '0;
    phase_acc   = '0;
    on_cnt      = '0;
    rev_half    = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults, brake first
    queue_ticks(1'b0, 1);
    queue_ticks(1'b1, 2);
    wait_idle(2000);
    // single-tick carrier, amplitude above full scale, quarter-turn steps
    write_reg(CFG_CARRIER_TICKS, 32'd1);
    write_reg(CFG_PHASE_STEP, 32'h4000_0000);
    write_reg(CFG_AMPLITUDE, 32'h1FFF);
    queue_ticks(1'b1, 4);
    wait_idle(2000);
    // four-tick carrier across negative peak, zero, peak and zero
    write_reg(CFG_CARRIER_TICKS, 32'd4);
    queue_ticks(1'b1, 13);
    wait_idle(2000);
    // zero length, zero amplitude, full step, unknown register
    write_reg(CFG_CARRIER_TICKS, 32'd0);
    write_reg(CFG_AMPLITUDE, 32'd0);
    write_reg(CFG_PHASE_STEP, 32'hFFFF_FFFF);
    write_reg(CFG_UNUSED_INDEX, $urandom());
    queue_ticks(1'b1, 3);
    queue_ticks(1'b0, 1);
    wait_idle(2000);
    // longest carrier at full scale, no phase advance
    write_reg(CFG_CARRIER_TICKS, 32'hFFFF);
    write_reg(CFG_PHASE_STEP, 32'd0);
    write_reg(CFG_AMPLITUDE, {19'd0, AMP_FULL_SCALE});
    queue_ticks(1'b1, 2);
    queue_ticks(1'b0, 1);
    wait_idle(2000);
    settings_run = 5;

    for (int ph = 0; ph < PHASES; ph++) begin
      sel = $urandom_range(0, 15);
      case (sel)
        0:       v = 32'd0;
        1:       v = 32'd1;
        2:       v = 32'hFFFF;
        3:       v = $urandom_range(0, 65535);
        default: v = $urandom_range(2, 40);
      endcase
      write_reg(CFG_CARRIER_TICKS, ($urandom() & 32'hFFFF_0000) | (v & 32'hFFFF));
      sel = $urandom_range(0, 7);
      case (sel)
        0:       v = 32'd0;
        1:       v = 32'hFFFF_FFFF;
        2:       v = 32'h8000_0000;
        default: v = $urandom();
      endcase
      write_reg(CFG_PHASE_STEP, v);
      sel = $urandom_range(0, 7);
      case (sel)
        0:       v = 32'd0;
        1:       v = 32'd4096;
        2:       v = 32'h1FFF;
        3:       v = $urandom_range(4097, 8191);
        default: v = $urandom_range(0, 4096);
      endcase
      write_reg(CFG_AMPLITUDE, ($urandom() & 32'hFFFF_E000) | (v & 32'h1FFF));
      if ($urandom_range(0, 2) == 0) write_reg(CFG_UNUSED_INDEX, $urandom());
      in_pace  = (ph == 0) ? PACE_FULL : pace_t'($urandom_range(0, 2));
      out_pace = (ph == 0) ? PACE_FULL : pace_t'($urandom_range(0, 2));
      n = 0;
      while (n < PHASE_TICKS) begin
        burst = $urandom_range(4, 60);
        if ($urandom_range(0, 3) == 0) burst = $urandom_range(1, 3);
        queue_ticks(1'b1, burst);
        n += burst;
        if ($urandom_range(0, 2) == 0) begin
          burst = $urandom_range(1, 3);
          queue_ticks(1'b0, burst);
          n += burst;
        end
      end
      wait_idle(50000);
      settings_run++;
    end

    wait_idle(50000);
    repeat (16) @(posedge clk);
    if (drive_expected.size() != 0) begin
      mismatches += drive_expected.size();
      $display("%0d drive transfers never arrived", drive_expected.size());
    end
    $display("Sent %0d ticks (%0d brake) over %0d register settings", ticks_sent,
             brakes_sent, settings_run);
    $display("Checked %0d drive transfers, %0d carrier starts, %0d mismatches",
             drives_seen, starts_seen, mismatches);
    if (mismatches == 0)
      $display("sine_pwm_h_bridge_generator regression: pass");
    else
      $display("sine_pwm_h_bridge_generator regression: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/spwm_pkg.sv
sv/spwm_in_if.sv
sv/spwm_out_if.sv
sv/spwm_ctrl.sv
sv/spwm_dp.sv
sv/sine_pwm_h_bridge_generator.sv
bench/sine_pwm_h_bridge_generator_tb.sv
